@@ src/hsvrgb_pkg.sv @@
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter.
// Used by hsvrgb_div60 and hsv_to_rgb_core; no dependencies.

package hsvrgb_pkg;

  // Hue input width and range.
  localparam int HUE_W = 9;
  localparam logic [HUE_W-1:0] HUE_TOP = 9'd360;

  // Sector boundaries in degrees.
  localparam logic [HUE_W-1:0] DEG_60  = 9'd60;
  localparam logic [HUE_W-1:0] DEG_120 = 9'd120;
  localparam logic [HUE_W-1:0] DEG_180 = 9'd180;
  localparam logic [HUE_W-1:0] DEG_240 = 9'd240;
  localparam logic [HUE_W-1:0] DEG_300 = 9'd300;

  // Weight 60 - |(H mod 120) - 60| spans 0..60.
  localparam int WEIGHT_W = 6;

  // Divide by 60 as a shift by 2 and a divide by 15; half of 60 rounds.
  localparam int DIV_SHIFT = 2;
  localparam int DIV_ODD   = 15;
  localparam int DIV_HALF  = 30;

  localparam int DEFAULT_CHANNEL_BITS = 8;

  // Hue sextants, named by the color at their start.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,  // (C, X, 0)
    SEC_YELLOW  = 3'd1,  // (X, C, 0)
    SEC_GREEN   = 3'd2,  // (0, C, X)
    SEC_CYAN    = 3'd3,  // (0, X, C)
    SEC_BLUE    = 3'd4,  // (X, 0, C)
    SEC_MAGENTA = 3'd5   // (C, 0, X)
  } sector_t;

endpackage

@@ src/hsvrgb_div60.sv @@
// hsvrgb_div60: registered round(num / 60) by reciprocal multiplication.
// Depends on hsvrgb_pkg for the divider split constants.

module hsvrgb_div60 #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::DEFAULT_CHANNEL_BITS
) (
  input  logic                     clk,
  input  logic [CHANNEL_BITS+5:0]  num,
  output logic [CHANNEL_BITS-1:0]  quot_r
);

  localparam int NUM_W = CHANNEL_BITS + 6;
  localparam int A_W   = NUM_W - hsvrgb_pkg::DIV_SHIFT;
  // Exact floor division by 15 for any A_W-bit value: K = A_W + ceil(log2 15).
  localparam int K     = A_W + 4;
  localparam int R_W   = K - 3;
  localparam logic [R_W-1:0] RECIP = R_W'(((64'd1 << K) + 64'(hsvrgb_pkg::DIV_ODD - 1))
                                          / 64'(hsvrgb_pkg::DIV_ODD));
  localparam int P_W   = A_W + R_W;

  logic [NUM_W-1:0] biased;
  logic [A_W-1:0]   quarter;
  logic [P_W-1:0]   prod;
  logic [CHANNEL_BITS-1:0] quot_nxt;

  // Bias for round-half-up, drop the factor of four, then scale by 1/15.
  assign biased   = num + NUM_W'(hsvrgb_pkg::DIV_HALF);
  assign quarter  = biased[NUM_W-1:hsvrgb_pkg::DIV_SHIFT];
  assign prod     = P_W'(quarter) * P_W'(RECIP);
  assign quot_nxt = prod[K+CHANNEL_BITS-1:K];

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

endmodule

@@ src/hsv_to_rgb_core.sv @@
// hsv_to_rgb_core: five-stage pipeline, one HSV pixel in and one RGB pixel out per clock.
// out_valid flags the stage 5 RGB registers; throughput 1 transaction/clock.
// busy stays low: every stage advances each cycle and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the stage valid bits only; data regs hold.
// Depends on hsvrgb_pkg and hsvrgb_div60.

module hsv_to_rgb_core #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::DEFAULT_CHANNEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvrgb_pkg::HUE_W-1:0]    in_hue,
  input  logic [CHANNEL_BITS-1:0]         in_saturation,
  input  logic [CHANNEL_BITS-1:0]         in_brightness,
  output logic                            out_valid,
  output logic [CHANNEL_BITS-1:0]         out_red,
  output logic [CHANNEL_BITS-1:0]         out_green,
  output logic [CHANNEL_BITS-1:0]         out_blue
);

  localparam int N   = CHANNEL_BITS;
  localparam int WW  = hsvrgb_pkg::WEIGHT_W;
  localparam logic [N-1:0]   MAXV = {N{1'b1}};
  // Half of MAXV rounded down, for round-half-up on divide by MAXV.
  localparam logic [2*N-1:0] HALF = (2*N)'(MAXV >> 1);

  // Each stage advances every clock; valid bits ride along with the data.
  logic [4:0] vld_r;
  logic [4:0] vld_nxt;

  // ---------------------------------------------------------------------------
  // Stage 1: clamp hue, pick sextant and weight, form S*V.
  // ---------------------------------------------------------------------------
  logic [hsvrgb_pkg::HUE_W-1:0] hue_c;
  logic [hsvrgb_pkg::HUE_W-1:0] wt_full;
  hsvrgb_pkg::sector_t          sec_nxt;
  logic [WW-1:0]                wt_nxt;

  hsvrgb_pkg::sector_t sec1_r;
  logic [WW-1:0]       wt1_r;
  logic [N-1:0]        val1_r;
  logic [2*N-1:0]      sv1_r;

  always_comb begin
    // Hue above full circle acts as 360, which lands on pure red like 0.
    hue_c = (in_hue > hsvrgb_pkg::HUE_TOP) ? hsvrgb_pkg::HUE_TOP : in_hue;

    priority if (hue_c < hsvrgb_pkg::DEG_60) begin
      sec_nxt = hsvrgb_pkg::SEC_RED;
    end else if (hue_c < hsvrgb_pkg::DEG_120) begin
      sec_nxt = hsvrgb_pkg::SEC_YELLOW;
    end else if (hue_c < hsvrgb_pkg::DEG_180) begin
      sec_nxt = hsvrgb_pkg::SEC_GREEN;
    end else if (hue_c < hsvrgb_pkg::DEG_240) begin
      sec_nxt = hsvrgb_pkg::SEC_CYAN;
    end else if (hue_c < hsvrgb_pkg::DEG_300) begin
      sec_nxt = hsvrgb_pkg::SEC_BLUE;
    end else begin
      sec_nxt = hsvrgb_pkg::SEC_MAGENTA;
    end

    // Weight rises across even sextants and falls across odd ones.
    unique case (sec_nxt)
      hsvrgb_pkg::SEC_RED:     wt_full = hue_c;
      hsvrgb_pkg::SEC_YELLOW:  wt_full = hsvrgb_pkg::DEG_120 - hue_c;
      hsvrgb_pkg::SEC_GREEN:   wt_full = hue_c - hsvrgb_pkg::DEG_120;
      hsvrgb_pkg::SEC_CYAN:    wt_full = hsvrgb_pkg::DEG_240 - hue_c;
      hsvrgb_pkg::SEC_BLUE:    wt_full = hue_c - hsvrgb_pkg::DEG_240;
      hsvrgb_pkg::SEC_MAGENTA: wt_full = hsvrgb_pkg::HUE_TOP - hue_c;
      default:                 wt_full = '0;
    endcase
    wt_nxt = wt_full[WW-1:0];
  end

  always_ff @(posedge clk) begin
    sec1_r <= sec_nxt;
    wt1_r  <= wt_nxt;
    val1_r <= in_brightness;
    sv1_r  <= (2*N)'(in_saturation) * (2*N)'(in_brightness);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: chroma C = round(S*V / MAXV).
  // With MAXV = 2^N - 1: num = q0*2^N + lo, so num - q0*MAXV = lo + q0,
  // which stays below 2*MAXV; one compare finishes the quotient.
  // ---------------------------------------------------------------------------
  logic [2*N-1:0] num2;
  logic [N:0]     rem2;
  logic [N-1:0]   chroma_nxt;

  hsvrgb_pkg::sector_t sec2_r;
  logic [WW-1:0]       wt2_r;
  logic [N-1:0]        val2_r;
  logic [N-1:0]        chroma2_r;

  always_comb begin
    num2       = sv1_r + HALF;
    rem2       = {1'b0, num2[N-1:0]} + {1'b0, num2[2*N-1:N]};
    chroma_nxt = num2[2*N-1:N] + N'(rem2 >= {1'b0, MAXV});
  end

  always_ff @(posedge clk) begin
    sec2_r    <= sec1_r;
    wt2_r     <= wt1_r;
    val2_r    <= val1_r;
    chroma2_r <= chroma_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: C * weight, and offset m = V - C.
  // ---------------------------------------------------------------------------
  hsvrgb_pkg::sector_t sec3_r;
  logic [N-1:0]        chroma3_r;
  logic [N-1:0]        ofs3_r;
  logic [N+WW-1:0]     cw3_r;

  always_ff @(posedge clk) begin
    sec3_r    <= sec2_r;
    chroma3_r <= chroma2_r;
    ofs3_r    <= val2_r - chroma2_r;
    cw3_r     <= (N+WW)'(chroma2_r) * (N+WW)'(wt2_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: X = round(C * weight / 60) in the divider's register.
  // ---------------------------------------------------------------------------
  hsvrgb_pkg::sector_t sec4_r;
  logic [N-1:0]        chroma4_r;
  logic [N-1:0]        ofs4_r;
  logic [N-1:0]        xval4;

  hsvrgb_div60 #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div60 (
    .clk    (clk),
    .num    (cw3_r),
    .quot_r (xval4)
  );

  always_ff @(posedge clk) begin
    sec4_r    <= sec3_r;
    chroma4_r <= chroma3_r;
    ofs4_r    <= ofs3_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: place C and X by sextant, add m. No channel exceeds V.
  // ---------------------------------------------------------------------------
  logic [N-1:0] red_nxt;
  logic [N-1:0] green_nxt;
  logic [N-1:0] blue_nxt;
  logic [N-1:0] red_r;
  logic [N-1:0] green_r;
  logic [N-1:0] blue_r;

  always_comb begin
    unique case (sec4_r)
      hsvrgb_pkg::SEC_RED: begin
        red_nxt   = chroma4_r + ofs4_r;
        green_nxt = xval4 + ofs4_r;
        blue_nxt  = ofs4_r;
      end
      hsvrgb_pkg::SEC_YELLOW: begin
        red_nxt   = xval4 + ofs4_r;
        green_nxt = chroma4_r + ofs4_r;
        blue_nxt  = ofs4_r;
      end
      hsvrgb_pkg::SEC_GREEN: begin
        red_nxt   = ofs4_r;
        green_nxt = chroma4_r + ofs4_r;
        blue_nxt  = xval4 + ofs4_r;
      end
      hsvrgb_pkg::SEC_CYAN: begin
        red_nxt   = ofs4_r;
        green_nxt = xval4 + ofs4_r;
        blue_nxt  = chroma4_r + ofs4_r;
      end
      hsvrgb_pkg::SEC_BLUE: begin
        red_nxt   = xval4 + ofs4_r;
        green_nxt = ofs4_r;
        blue_nxt  = chroma4_r + ofs4_r;
      end
      hsvrgb_pkg::SEC_MAGENTA: begin
        red_nxt   = chroma4_r + ofs4_r;
        green_nxt = ofs4_r;
        blue_nxt  = xval4 + ofs4_r;
      end
      default: begin
        red_nxt   = ofs4_r;
        green_nxt = ofs4_r;
        blue_nxt  = ofs4_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  // ---------------------------------------------------------------------------
  // Valid pipeline: advance one stage per clock, drop everything on reset.
  // ---------------------------------------------------------------------------
  assign vld_nxt = {vld_r[3:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Fully pipelined with no back-pressure: never busy.
  assign busy      = 1'b0;
  assign out_valid = vld_r[4];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule
